[rtl/cdd_pkg.sv]
// Shared types, constants and calendar helpers for the date decrement block.
`default_nettype none

package cdd_pkg;

  typedef enum logic [2:0] {
    REQ_DAY        = 3'd0,
    REQ_WEEK       = 3'd1,
    REQ_MONTH      = 3'd2,
    REQ_YEAR       = 3'd3,
    REQ_DECADE     = 3'd4,
    REQ_CENTURY    = 3'd5,
    REQ_MILLENNIUM = 3'd6
  } req_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic out_load;
  } cdd_cmd_t;

  typedef struct packed {
    logic step_mode;
    logic rem_zero;
  } cdd_status_t;

  localparam int MULT_W      = 10;
  localparam int MAG_W       = 16;
  localparam int DIV25_SHIFT = 21;
  localparam int DIV25_PW    = MAG_W + 17;
  localparam logic [16:0] DIV25_MUL = 17'd83887;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_ONE   = 5'd1;
  localparam logic [4:0] DEC_DAYS  = 5'd31;

  localparam logic [4:0] MONTH_LEN [0:11] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  function automatic logic [4:0] days_of(logic [3:0] month, logic leap);
    logic [3:0] idx;
    logic [4:0] len;
    idx = month - 4'd1;
    unique case (month) inside
      MONTH_FEB:                       len = leap ? 5'd29 : 5'd28;
      4'd1, [4'd3:4'd12]:              len = MONTH_LEN[idx];
      default:                         len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [MULT_W-1:0] mult_of(logic [2:0] kind);
    logic [MULT_W-1:0] mult;
    unique case (kind) inside
      REQ_DAY, REQ_MONTH, REQ_YEAR: mult = MULT_W'(1);
      REQ_WEEK:                     mult = MULT_W'(7);
      REQ_DECADE:                   mult = MULT_W'(10);
      REQ_CENTURY:                  mult = MULT_W'(100);
      REQ_MILLENNIUM:               mult = MULT_W'(1000);
      default:                      mult = '0;
    endcase
    return mult;
  endfunction

endpackage

`default_nettype wire

[rtl/cdd_dp.sv]
// Datapath: date registers, day and month step logic, leap test, count multiplier.
`default_nettype none

module cdd_dp #(
  parameter int COUNT_WIDTH = 12,
  parameter int YEAR_WIDTH  = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  cdd_pkg::cdd_cmd_t    cmd_i,
  output cdd_pkg::cdd_status_t status_o,
  input  wire  [2:0]           req_type_i,
  input  wire  [11:0]          step_count_i,
  input  wire  [4:0]           in_day_i,
  input  wire  [3:0]           in_month_i,
  input  wire  [15:0]          in_year_i,
  output logic [4:0]           out_day_o,
  output logic [3:0]           out_month_o,
  output logic [15:0]          out_year_o
);
  import cdd_pkg::*;

  localparam int PW = COUNT_WIDTH + MULT_W;
  localparam int RW = COUNT_WIDTH + 3;
  localparam int SW = (PW > YEAR_WIDTH) ? PW : YEAR_WIDTH;

  logic [2:0]             kind_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic [4:0]             day_q, day_d;
  logic [3:0]             mon_q, mon_d;
  logic [YEAR_WIDTH-1:0]  year_q, year_d;
  logic [PW-1:0]          prod_q, prod_c;
  logic [RW-1:0]          rem_q;
  logic                   leap_q, leap_c;
  logic [4:0]             out_day_q;
  logic [3:0]             out_mon_q;
  logic [YEAR_WIDTH-1:0]  out_year_q, out_year_d;

  logic [3:0]             mon_dec;
  logic [YEAR_WIDTH-1:0]  year_dec;
  logic [4:0]             len;
  logic [YEAR_WIDTH-1:0]  mag;
  logic [MAG_W-1:0]       mag16;
  logic [DIV25_PW-1:0]    q_prod;
  logic [MAG_W-1:0]       quo, quo25;
  logic                   div25, div4, div16;
  logic [SW-1:0]          diff;
  logic                   year_mode;

  // leap test on the signed year: divisible by 25 via reciprocal multiply
  always_comb begin
    mag    = year_q[YEAR_WIDTH-1] ? (~year_q + YEAR_WIDTH'(1)) : year_q;
    mag16  = MAG_W'(mag);
    q_prod = DIV25_PW'(mag16) * DIV25_PW'(DIV25_MUL);
    quo    = MAG_W'(q_prod[DIV25_PW-1:DIV25_SHIFT]);
    quo25  = (quo << 4) + (quo << 3) + quo;
    div25  = (mag16 == quo25);
    div4   = (mag[1:0] == 2'd0);
    div16  = (mag[3:0] == 4'd0);
    leap_c = (div16 && div25) || (div4 && !div25);
  end

  assign prod_c = PW'(cnt_q) * PW'(mult_of(kind_q));

  always_comb begin
    mon_dec  = mon_q - 4'd1;
    year_dec = year_q - YEAR_WIDTH'(1);
    day_d    = day_q;
    mon_d    = mon_q;
    year_d   = year_q;
    len      = days_of(mon_dec, leap_q);
    if (kind_q == REQ_MONTH) begin
      if (mon_q == MONTH_JAN) begin
        mon_d  = MONTH_DEC;
        year_d = year_dec;
        len    = DEC_DAYS;
      end else begin
        mon_d = mon_dec;
      end
      day_d = (day_q > len) ? len : day_q;
    end else if (day_q == DAY_ONE) begin
      if (mon_q == MONTH_JAN) begin
        day_d  = DEC_DAYS;
        mon_d  = MONTH_DEC;
        year_d = year_dec;
      end else begin
        mon_d = mon_dec;
        day_d = len;
      end
    end else begin
      day_d = day_q - 5'd1;
    end
  end

  always_comb begin
    year_mode  = kind_q inside {REQ_YEAR, REQ_DECADE, REQ_CENTURY, REQ_MILLENNIUM};
    diff       = SW'(year_q) - SW'(prod_q);
    out_year_d = year_mode ? diff[YEAR_WIDTH-1:0] : year_q;
  end

  always_ff @(posedge clk_i) begin
    leap_q <= leap_c;
    if (cmd_i.load) begin
      kind_q <= req_type_i;
      cnt_q  <= COUNT_WIDTH'(step_count_i);
      day_q  <= in_day_i;
      mon_q  <= in_month_i;
      year_q <= in_year_i[YEAR_WIDTH-1:0];
    end
    if (cmd_i.prep) begin
      prod_q <= prod_c;
      rem_q  <= prod_c[RW-1:0];
    end
    if (cmd_i.step) begin
      rem_q  <= rem_q - RW'(1);
      day_q  <= day_d;
      mon_q  <= mon_d;
      year_q <= year_d;
    end
    if (cmd_i.out_load) begin
      out_day_q  <= day_q;
      out_mon_q  <= mon_q;
      out_year_q <= out_year_d;
    end
  end

  assign status_o.step_mode = kind_q inside {REQ_DAY, REQ_WEEK, REQ_MONTH};
  assign status_o.rem_zero  = (rem_q == '0);

  assign out_day_o   = out_day_q;
  assign out_month_o = out_mon_q;
  assign out_year_o  = 16'($signed(out_year_q));

  a_step_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> rem_q == $past(rem_q) - RW'(1))
    else $error("remaining count did not advance by one");

  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !status_o.rem_zero && status_o.step_mode)
    else $error("step issued with no work left");

endmodule

`default_nettype wire

[rtl/cdd_ctrl.sv]
// Controller: request sequencing and output register handshake.
`default_nettype none

module cdd_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  cdd_pkg::cdd_status_t status_i,
  output cdd_pkg::cdd_cmd_t    cmd_o
);
  import cdd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PREP = 3'b010,
    ST_RUN  = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.step_mode && !status_i.rem_zero) begin
          cmd_o.step = 1'b1;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_PREP)
    else $error("accepted request did not enter prep");

  a_step_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |=> state_q == ST_RUN)
    else $error("left run while stepping");

  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q && in_ready_o)
    else $error("finished request not presented");

endmodule

`default_nettype wire

[rtl/calendar_date_decrement.sv]
// Top level: Gregorian date decrement by day, week, month, year, decade, century or millennium units.
`default_nettype none

// Moves a date back by step_count units of the kind given in tuser. Each
// request is accepted in the idle state and its count is set up in the prep
// state; the run state then steps the date back by days (count steps in day
// mode, 7 * count in week mode) or months (count steps in month mode) and
// loads the result once the output register is free; year, decade, century
// and millennium requests make no steps. The result sits in an output
// register, so the next request is taken while it waits for the sink.
module calendar_date_decrement #(
  parameter int COUNT_WIDTH = 12,
  parameter int YEAR_WIDTH  = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // step_count[11:0], in_day[16:12], in_month[20:17], in_year[36:21], zero
  input  wire  [39:0] s_axis_tdata_i,
  // req_type[2:0]
  input  wire  [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // out_day[4:0], out_month[8:5], out_year[24:9], zero
  output logic [31:0] m_axis_tdata_o
);
  import cdd_pkg::*;

  cdd_cmd_t    cmd;
  cdd_status_t status;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [15:0] out_year;

  cdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cdd_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .YEAR_WIDTH  (YEAR_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_type_i   (s_axis_tuser_i),
    .step_count_i (s_axis_tdata_i[11:0]),
    .in_day_i     (s_axis_tdata_i[16:12]),
    .in_month_i   (s_axis_tdata_i[20:17]),
    .in_year_i    (s_axis_tdata_i[36:21]),
    .out_day_o    (out_day),
    .out_month_o  (out_month),
    .out_year_o   (out_year)
  );

  assign m_axis_tdata_o = {7'd0, out_year, out_month, out_day};

endmodule

`default_nettype wire

[dv/calendar_date_decrement_test.sv]
// Self-checking testbench for calendar_date_decrement: directed and random stream requests against a date predictor.
module calendar_date_decrement_test;
  import cdd_pkg::*;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 150000;
  localparam int MAX_REPORTS = 10;
  localparam logic [4:0] DAYS_IN_MONTH [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] count;
    date_t       date;
  } date_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [31:0] m_tdata;

  date_req_t pending_reqs[$];
  date_t     expected_dates[$];
  date_req_t cur_req;
  logic      steady = 1'b0;
  int        stall_asked = 0;
  int        stall_done = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;
  int        req_count[8] = '{default: 0};
  int        checked = 0;
  int        mismatches = 0;

  calendar_date_decrement u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic is_leap(logic signed [15:0] y);
    int s;
    s = y;
    return (s % 400 == 0) || (s % 4 == 0 && s % 100 != 0);
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] m, logic [15:0] y);
    if (m < 4'd1 || m > 4'd12) return 5'd0;
    if (m == 4'd2) return is_leap(y) ? 5'd29 : 5'd28;
    return DAYS_IN_MONTH[m - 4'd1];
  endfunction

  function automatic date_t day_earlier(date_t dt);
    if (dt.day == 5'd1) begin
      if (dt.month == 4'd1) begin
        dt.day = 5'd31;
        dt.month = 4'd12;
        dt.year = dt.year - 16'd1;
      end else begin
        dt.month = dt.month - 4'd1;
        dt.day = month_days(dt.month, dt.year);
      end
    end else begin
      dt.day = dt.day - 5'd1;
    end
    return dt;
  endfunction

  function automatic date_t month_earlier(date_t dt);
    logic [4:0] len;
    if (dt.month == 4'd1) begin
      dt.month = 4'd12;
      dt.year = dt.year - 16'd1;
    end else begin
      dt.month = dt.month - 4'd1;
    end
    len = month_days(dt.month, dt.year);
    if (dt.day > len) dt.day = len;
    return dt;
  endfunction

  function automatic date_t subtract_date(date_req_t r);
    date_t dt;
    int    n;
    dt = r.date;
    case (r.kind)
      REQ_DAY, REQ_WEEK: begin
        n = (r.kind == REQ_WEEK) ? r.count * 7 : r.count;
        for (int i = 0; i < n; i++) dt = day_earlier(dt);
      end
      REQ_MONTH: begin
        for (int i = 0; i < r.count; i++) dt = month_earlier(dt);
      end
      REQ_YEAR:       dt.year = dt.year - 16'(r.count);
      REQ_DECADE:     dt.year = dt.year - 16'(r.count * 10);
      REQ_CENTURY:    dt.year = dt.year - 16'(r.count * 100);
      REQ_MILLENNIUM: dt.year = dt.year - 16'(r.count * 1000);
      default: ;
    endcase
    return dt;
  endfunction

  function automatic logic idle_roll();
    return !steady && ($urandom_range(99) < 35);
  endfunction

  task automatic add_req(logic [2:0] kind, int count, int day, int month, int year);
    date_req_t r;
    r.kind = kind;
    r.count = 12'(count);
    r.date.day = 5'(day);
    r.date.month = 4'(month);
    r.date.year = 16'(year);
    pending_reqs.push_back(r);
  endtask

  function automatic date_req_t random_req();
    date_req_t r;
    int        pick;
    pick = $urandom_range(99);
    r.kind = (pick < 90) ? 3'($urandom_range(6)) : 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 75) r.count = 12'($urandom_range(40));
    else if (pick < 95) r.count = 12'($urandom_range(500));
    else r.count = 12'($urandom_range(4095));
    r.date.year = 16'($urandom);
    if ($urandom_range(99) < 88) begin
      r.date.month = 4'($urandom_range(12, 1));
      r.date.day = 5'($urandom_range(month_days(r.date.month, r.date.year), 1));
    end else begin
      r.date.month = 4'($urandom_range(15));
      r.date.day = 5'($urandom_range(31));
    end
    return r;
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || s_valid || expected_dates.size() != 0)
      @(posedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_ready) begin
      if (s_valid) begin
        expected_dates.push_back(subtract_date(cur_req));
        req_count[cur_req.kind]++;
      end
      if (pending_reqs.size() != 0 && !idle_roll()) begin
        cur_req = pending_reqs.pop_front();
        s_tdata <= {3'b000, cur_req.date, cur_req.count};
        s_tuser <= cur_req.kind;
        s_valid <= 1'b1;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      hold_left <= 0;
    end else if (stall_done != stall_asked) begin
      stall_done <= stall_done + 1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !idle_roll();
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    date_t got;
    date_t want;
    if (rst_ni && m_valid && m_tready) begin
      got = date_t'(m_tdata[24:0]);
      if (expected_dates.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: day %0d month %0d year %0d",
                   got.day, got.month, $signed(got.year));
        mismatches++;
      end else begin
        want = expected_dates.pop_front();
        checked++;
        if (got.day != want.day || got.month != want.month || got.year != want.year) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     want.day, want.month, $signed(want.year),
                     got.day, got.month, $signed(got.year));
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_req(REQ_DAY, 1, 1, 1, 0);
    add_req(REQ_DAY, 1, 1, 1, -32768);
    add_req(REQ_DAY, 1, 1, 3, 2000);
    add_req(REQ_DAY, 1, 1, 3, 1900);
    add_req(REQ_DAY, 1, 1, 3, -4);
    add_req(REQ_DAY, 0, 15, 6, 2023);
    add_req(REQ_DAY, 4095, 1, 1, 0);
    add_req(REQ_WEEK, 4095, 31, 12, 32767);
    add_req(REQ_WEEK, 1, 3, 3, 2024);
    add_req(REQ_MONTH, 1, 31, 3, 2023);
    add_req(REQ_MONTH, 13, 31, 1, 2024);
    add_req(REQ_MONTH, 4095, 31, 12, -32768);
    add_req(REQ_YEAR, 4095, 1, 1, -32768);
    add_req(REQ_DECADE, 4095, 31, 12, 32767);
    add_req(REQ_CENTURY, 4095, 29, 2, 32767);
    add_req(REQ_MILLENNIUM, 4095, 1, 6, 32767);
    add_req(REQ_MILLENNIUM, 0, 31, 12, -1);
    add_req(REQ_UNUSED, 100, 31, 15, 12345);
    add_req(REQ_DAY, 1, 0, 5, 7);
    add_req(REQ_DAY, 1, 1, 0, 2000);
    add_req(REQ_DAY, 3, 1, 15, 1);
    add_req(REQ_MONTH, 2, 5, 13, 100);
    add_req(REQ_DAY, 2, 31, 2, 2023);
    add_req(REQ_MONTH, 12, 31, 2, 2023);
    drain();

    repeat (50) pending_reqs.push_back(random_req());
    drain();

    steady = 1'b1;
    repeat (40) pending_reqs.push_back(random_req());
    drain();

    // hold off the sink while the source keeps offering
    steady = 1'b0;
    stall_asked = stall_asked + 1;
    repeat (30) begin
      date_req_t r;
      r = random_req();
      if (r.count > 12'd20) r.count = 12'($urandom_range(20));
      pending_reqs.push_back(r);
    end
    drain();
    repeat (20) @(posedge clk_i);

    $display("requests by unit: day %0d week %0d month %0d year %0d decade %0d",
             req_count[0], req_count[1], req_count[2], req_count[3], req_count[4]);
    $display("century %0d millennium %0d unused %0d; %0d results compared, %0d mismatches",
             req_count[5], req_count[6], req_count[7], checked, mismatches);
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
